>>> rtl/pes_header_parser_defines.svh
// Assertion macros for the PES header parser.
`ifndef PES_HEADER_PARSER_DEFINES_SVH
`define PES_HEADER_PARSER_DEFINES_SVH
`define PHP_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("check failed");
`define PHP_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("check failed");
`endif

>>> rtl/php_pkg.sv
// Shared types and constants of the PES header parser.
package php_pkg;
    localparam logic [7:0] ID_PADDING  = 8'hbe;
    localparam logic [7:0] ID_PRIVATE2 = 8'hbf;
    localparam logic [1:0] SYN_MPEG1 = 2'd0;
    localparam logic [1:0] SYN_MPEG2 = 2'd1;
    localparam logic [1:0] SYN_NONE  = 2'd2;
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LONG   = 2'd1;
    localparam logic [1:0] ST_CUT    = 2'd2;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [15:0] es_id;
        logic [1:0]  syntax;
        logic        pts_valid;
        logic [32:0] pts;
        logic        dts_valid;
        logic [32:0] dts;
        logic [15:0] packet_length;
        logic [16:0] consumed;
        logic        cut;
    } php_rec_t;

    typedef struct packed {
        logic     valid;
        php_rec_t rec;
    } php_push_t;
endpackage

>>> rtl/php_front.sv
// Byte-level header walker: tracks phase and gathers header fields.
module php_front import php_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [7:0]  data_byte,
    input  logic        packet_start,
    output php_push_t   push
);
    typedef enum logic [18:0] {
        PH_IDLE     = 19'd1 << 0,  PH_START   = 19'd1 << 1,  PH_FIRST   = 19'd1 << 2,
        PH_M1_STUFF = 19'd1 << 3,  PH_M1_STD  = 19'd1 << 4,  PH_M1_AFTER = 19'd1 << 5,
        PH_M1_TS    = 19'd1 << 6,  PH_M2_FLAGS = 19'd1 << 7, PH_M2_HDL  = 19'd1 << 8,
        PH_M2_TS    = 19'd1 << 9,  PH_M2_FIX  = 19'd1 << 10, PH_M2_EXTF = 19'd1 << 11,
        PH_M2_PRIV  = 19'd1 << 12, PH_M2_PACKLEN = 19'd1 << 13,
        PH_M2_PACKSKIP = 19'd1 << 14, PH_M2_SEQ = 19'd1 << 15,
        PH_M2_EXTLEN = 19'd1 << 16, PH_M2_EXTID = 19'd1 << 17, PH_M2_TAIL = 19'd1 << 18
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bc_reg, bc_next;
    logic [15:0] plen_reg, plen_next;
    logic [16:0] cons_reg, cons_next;
    logic [7:0]  hf_reg, hf_next, ef_reg, ef_next, hdl_reg, hdl_next, skip_reg, skip_next;
    logic [15:0] id_reg, id_next;
    logic [32:0] pts_reg, pts_next, dts_reg, dts_next;
    logic [1:0]  tsf_reg, tsf_next;
    logic        emit;
    logic        emit_cut;
    phase_t      ephase;

    function automatic logic [32:0] ts_upd(input logic [32:0] a, input logic [2:0] k,
                                           input logic [7:0] c);
        logic [32:0] r;
        r = a;
        case (k)
            3'd0: r = {c[3:1], 30'd0};
            3'd1: r = a | {3'd0, c, 22'd0};
            3'd2: r = a | {11'd0, c[7:1], 15'd0};
            3'd3: r = a | {18'd0, c, 7'd0};
            default: r = a | {26'd0, c[7:1]};
        endcase
        return r;
    endfunction

    function automatic logic [3:0] fix_n(input logic [7:0] h);
        return (h[5] ? 4'd6 : 4'd0) + (h[4] ? 4'd3 : 4'd0) + {3'd0, h[3]} + {3'd0, h[2]}
               + (h[1] ? 4'd2 : 4'd0);
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [3:0] tst;
        logic [3:0] n;
        logic [2:0] chain;
        logic       m1ts;
        logic       m1ev;
        c = data_byte;
        phase_next = phase_reg; bc_next = bc_reg; plen_next = plen_reg;
        cons_next = cons_reg; hf_next = hf_reg; ef_next = ef_reg; hdl_next = hdl_reg;
        skip_next = skip_reg; id_next = id_reg; pts_next = pts_reg; dts_next = dts_reg;
        tsf_next = tsf_reg;
        emit = 1'b0; emit_cut = 1'b0; ephase = phase_reg;
        chain = 3'd0; m1ts = 1'b0; m1ev = 1'b0;
        tst = hf_reg[6] ? 4'd10 : 4'd5;
        n = 4'd0;
        if (en) begin
            if (packet_start) begin
                emit = (phase_reg != PH_IDLE); emit_cut = 1'b1;
                phase_next = PH_START; bc_next = 4'd1; plen_next = '0; cons_next = '0;
                hf_next = '0; ef_next = '0; hdl_next = '0; skip_next = '0; id_next = '0;
                pts_next = '0; dts_next = '0; tsf_next = '0;
            end else if (phase_reg != PH_IDLE) begin
                if (phase_reg != PH_START) cons_next = cons_reg + 17'd1;
                case (phase_reg)
                    PH_START: begin
                        if (bc_reg == 4'd3) id_next = {8'd0, c};
                        else if (bc_reg == 4'd4) plen_next = {c, 8'd0};
                        else if (bc_reg == 4'd5) plen_next = {plen_reg[15:8], c};
                        bc_next = bc_reg + 4'd1;
                        if (bc_reg == 4'd5) begin
                            if (id_reg[7:0] == ID_PADDING || id_reg[7:0] == ID_PRIVATE2)
                                emit = 1'b1;
                            else phase_next = PH_FIRST;
                        end
                    end
                    PH_FIRST: begin
                        if (c[7:6] == 2'b10) phase_next = PH_M2_FLAGS;
                        else m1ev = 1'b1;
                    end
                    PH_M1_STUFF: m1ev = 1'b1;
                    PH_M1_STD:   phase_next = PH_M1_AFTER;
                    PH_M1_AFTER: m1ts = 1'b1;
                    PH_M1_TS, PH_M2_TS: begin
                        if (bc_reg < 4'd5) pts_next = ts_upd(pts_reg, bc_reg[2:0], c);
                        else dts_next = ts_upd(dts_reg, 3'(bc_reg - 4'd5), c);
                        if (bc_reg == 4'd4) tsf_next[0] = 1'b1;
                        if (bc_reg == 4'd9) tsf_next[1] = 1'b1;
                        bc_next = bc_reg + 4'd1;
                        if (bc_next >= tst) begin
                            if (phase_reg == PH_M1_TS) emit = 1'b1;
                            else chain = 3'd2;
                        end
                    end
                    PH_M2_FLAGS: begin hf_next = c; phase_next = PH_M2_HDL; end
                    PH_M2_HDL:   begin hdl_next = c; chain = 3'd1; end
                    PH_M2_FIX: begin
                        skip_next = skip_reg - 8'd1;
                        if (skip_reg <= 8'd1) begin skip_next = '0; chain = 3'd3; end
                    end
                    PH_M2_EXTF: begin ef_next = c; chain = 3'd4; end
                    PH_M2_PRIV: begin
                        skip_next = skip_reg - 8'd1;
                        if (skip_reg <= 8'd1) begin skip_next = '0; chain = 3'd5; end
                    end
                    PH_M2_PACKLEN: begin
                        skip_next = c;
                        if (c == 8'd0) chain = 3'd6;
                        else phase_next = PH_M2_PACKSKIP;
                    end
                    PH_M2_PACKSKIP, PH_M2_SEQ: begin
                        skip_next = skip_reg - 8'd1;
                        if (skip_reg <= 8'd1) begin
                            skip_next = '0;
                            chain = (phase_reg == PH_M2_PACKSKIP) ? 3'd6 : 3'd7;
                        end
                    end
                    PH_M2_EXTLEN: begin
                        if (c[6:0] != 7'd0) phase_next = PH_M2_EXTID;
                        else chain = 3'd0;
                        if (c[6:0] == 7'd0) phase_next = PH_M2_TAIL;
                    end
                    PH_M2_EXTID: begin
                        if (!c[7]) id_next = {id_reg[7:0], c};
                        phase_next = PH_M2_TAIL;
                    end
                    default: phase_next = PH_M2_TAIL;
                endcase
                if (m1ev) begin
                    if (cons_next < {1'b0, plen_reg} && c[7]) phase_next = PH_M1_STUFF;
                    else if (c[7:6] == 2'b01) phase_next = PH_M1_STD;
                    else m1ts = 1'b1;
                end
                if (m1ts) begin
                    if (c[7:4] == 4'h2 || c[7:4] == 4'h3) begin
                        hf_next = (c[7:4] == 4'h3) ? 8'hc0 : 8'h80;
                        pts_next = ts_upd(pts_reg, 3'd0, c);
                        bc_next = 4'd1; phase_next = PH_M1_TS;
                    end else begin
                        emit = 1'b1; ephase = PH_M1_AFTER;
                    end
                end
                // walk the optional-field chain to the next state that consumes bytes
                if (chain == 3'd1) begin
                    if (hf_reg[7]) begin phase_next = PH_M2_TS; bc_next = '0; end
                    else chain = 3'd2;
                end
                if (chain == 3'd2) begin
                    n = fix_n(hf_reg);
                    if (n != 4'd0) begin phase_next = PH_M2_FIX; skip_next = {4'd0, n}; end
                    else chain = 3'd3;
                end
                if (chain == 3'd3) begin
                    if (hf_reg[0]) phase_next = PH_M2_EXTF;
                    else phase_next = PH_M2_TAIL;
                end
                if (chain == 3'd4) begin
                    if (c[7]) begin phase_next = PH_M2_PRIV; skip_next = 8'd16; end
                    else chain = 3'd5;
                end
                if (chain == 3'd5) begin
                    if (ef_next[6]) phase_next = PH_M2_PACKLEN;
                    else chain = 3'd6;
                end
                if (chain == 3'd6) begin
                    n = (ef_next[5] ? 4'd2 : 4'd0) + (ef_next[4] ? 4'd2 : 4'd0);
                    if (n != 4'd0) begin phase_next = PH_M2_SEQ; skip_next = {4'd0, n}; end
                    else chain = 3'd7;
                end
                if (chain == 3'd7) begin
                    if (ef_next[0]) phase_next = PH_M2_EXTLEN;
                    else phase_next = PH_M2_TAIL;
                end
                if (phase_next == PH_M2_TAIL && !emit) begin
                    if (cons_next >= 17'd3 + {9'd0, hdl_next}) begin
                        emit = 1'b1; ephase = PH_M2_TAIL;
                    end
                end
            end
            if (emit && !emit_cut) phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; bc_reg <= '0; plen_reg <= '0; cons_reg <= '0;
            hf_reg <= '0; ef_reg <= '0; hdl_reg <= '0; skip_reg <= '0; id_reg <= '0;
            pts_reg <= '0; dts_reg <= '0; tsf_reg <= '0;
            push.valid <= 1'b0;
        end else begin
            phase_reg <= phase_next; bc_reg <= bc_next; plen_reg <= plen_next;
            cons_reg <= cons_next; hf_reg <= hf_next; ef_reg <= ef_next;
            hdl_reg <= hdl_next; skip_reg <= skip_next; id_reg <= id_next;
            pts_reg <= pts_next; dts_reg <= dts_next; tsf_reg <= tsf_next;
            push.valid <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            if (emit_cut) begin
                push.rec.es_id <= id_reg; push.rec.pts_valid <= tsf_reg[0];
                push.rec.pts <= tsf_reg[0] ? pts_reg : '0;
                push.rec.dts_valid <= tsf_reg[1];
                push.rec.dts <= tsf_reg[1] ? dts_reg : '0;
                push.rec.consumed <= cons_reg;
                push.rec.syntax <= (phase_reg == PH_START || phase_reg == PH_FIRST) ?
                    SYN_NONE : ((phase_reg == PH_M1_STUFF || phase_reg == PH_M1_STD ||
                    phase_reg == PH_M1_AFTER || phase_reg == PH_M1_TS) ? SYN_MPEG1 :
                    SYN_MPEG2);
            end else begin
                push.rec.es_id <= id_next; push.rec.pts_valid <= tsf_next[0];
                push.rec.pts <= tsf_next[0] ? pts_next : '0;
                push.rec.dts_valid <= tsf_next[1];
                push.rec.dts <= tsf_next[1] ? dts_next : '0;
                push.rec.consumed <= cons_next;
                push.rec.syntax <= (phase_reg == PH_START || phase_reg == PH_FIRST) ?
                    SYN_NONE : ((ephase == PH_M1_AFTER || phase_reg == PH_M1_TS) ?
                    SYN_MPEG1 : SYN_MPEG2);
            end
            push.rec.packet_length <= emit_cut ? plen_reg : plen_next;
            push.rec.cut <= emit_cut;
        end
    end
endmodule

>>> rtl/php_queue.sv
// Short result queue between the walker and the output stage.
module php_queue import php_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  php_push_t push,
    output logic      space,
    output logic      q_valid,
    output php_rec_t  q_rec,
    input  logic      q_pop
);
    localparam int AW = $clog2(QDEPTH);
    php_rec_t      mem [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign q_valid = (cnt_reg != '0);
    assign q_rec   = mem[rp_reg];
    // hold room for an entry the walker may already have in flight
    assign space   = (cnt_reg + (AW+1)'(push.valid)) <= ((AW+1)'(1) + (AW+1)'(q_pop));

    always_ff @(posedge aclk) begin
        if (push.valid) mem[wp_reg] <= push.rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push.valid) wp_reg <= wp_reg + AW'(1);
            if (q_pop) rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(push.valid) - (AW+1)'(q_pop);
        end
    end
endmodule

>>> rtl/php_back.sv
// Output stage: works out payload size and status, drives the result channel.
module php_back import php_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  php_rec_t    q_rec,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_es_id,
    output logic [1:0]  m_syntax,
    output logic        m_pts_valid,
    output logic [32:0] m_pts,
    output logic        m_dts_valid,
    output logic [32:0] m_dts,
    output logic [15:0] m_body_size,
    output logic [1:0]  m_status
);
    logic        long_hdr;
    logic [16:0] diff;

    assign q_pop = q_valid && (!m_valid || m_ready);
    assign diff = {1'b0, q_rec.packet_length} - q_rec.consumed;
    assign long_hdr = q_rec.consumed > {1'b0, q_rec.packet_length};

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid <= 1'b0;
        else if (q_pop) m_valid <= 1'b1;
        else if (m_ready) m_valid <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_es_id <= q_rec.es_id; m_syntax <= q_rec.syntax;
            m_pts_valid <= q_rec.pts_valid; m_pts <= q_rec.pts;
            m_dts_valid <= q_rec.dts_valid; m_dts <= q_rec.dts;
            m_body_size <= (q_rec.cut || long_hdr) ? 16'd0 : diff[15:0];
            m_status <= q_rec.cut ? ST_CUT : (long_hdr ? ST_LONG : ST_OK);
        end
    end

`include "pes_header_parser_defines.svh"
    `PHP_ASSERT_IMP(a_pop_ok, aclk, aresetn, q_pop, q_valid)
    `PHP_ASSERT_NEXT(a_load, aclk, aresetn, q_pop, m_valid)
    `PHP_ASSERT_IMP(a_long_zero, aclk, aresetn, m_valid && m_status != ST_OK,
                    m_body_size == 16'd0)
endmodule

>>> rtl/pes_header_parser.sv
// Top level of the PES header parser.
//  channel | ports                 | role
//  input   | s_valid/s_ready, s_*  | one stream byte per transfer
//  result  | m_valid/m_ready, m_*  | one header summary per packet
// One byte a cycle while s_ready is high; the walker's combinational next-state step sets the rate.
// A result passes from the walker's push register through the result queue and the output register.
// s_ready drops while the two-entry result queue, counting a result still in
// the walker, has no room left for one more.
// Reset is synchronous, active low, and returns the walker to idle.
module pes_header_parser import php_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_packet_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_es_id,
    output logic [1:0]  m_syntax,
    output logic        m_pts_valid,
    output logic [32:0] m_pts,
    output logic        m_dts_valid,
    output logic [32:0] m_dts,
    output logic [15:0] m_body_size,
    output logic [1:0]  m_status
);
    php_push_t push;
    logic      space, q_valid, q_pop;
    php_rec_t  q_rec;

    assign s_ready = space;

    php_front u_front (.aclk, .aresetn, .en(s_valid && s_ready),
        .data_byte(s_data_byte), .packet_start(s_packet_start), .push);
    php_queue u_queue (.aclk, .aresetn, .push, .space, .q_valid, .q_rec, .q_pop);
    php_back u_back (.aclk, .aresetn, .q_valid, .q_rec, .q_pop, .m_valid, .m_ready,
        .m_es_id, .m_syntax, .m_pts_valid, .m_pts, .m_dts_valid, .m_dts,
        .m_body_size, .m_status);
endmodule

>>> verif/pes_header_parser_tb.sv
// Self-checking testbench for the PES header parser: packet stimulus and a header predictor.
module pes_header_parser_tb import php_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        PH_IDLE, PH_START, PH_FIRST, PH_M1_STUFF, PH_M1_STD, PH_M1_AFTER, PH_M1_TS,
        PH_M2_FLAGS, PH_M2_HDL, PH_M2_TS, PH_M2_FIX, PH_M2_EXTF, PH_M2_PRIV,
        PH_M2_PACKLEN, PH_M2_PACKSKIP, PH_M2_SEQ, PH_M2_EXTLEN, PH_M2_EXTID, PH_M2_TAIL
    } walk_t;

    typedef struct packed {
        logic [15:0] es_id;
        logic [1:0]  syntax;
        logic        pts_valid;
        logic [32:0] pts;
        logic        dts_valid;
        logic [32:0] dts;
        logic [15:0] body_size;
        logic [1:0]  status;
    } header_t;

    class pes_scoreboard;
        header_t     expected_headers[$];
        int          errors;
        int          headers_seen;
        int          cut_seen;
        int          long_seen;
        walk_t       phase;
        int          bcnt;
        logic [15:0] pkt_len;
        logic [16:0] used;
        logic [7:0]  hf;
        logic [7:0]  ef;
        logic [7:0]  hdl;
        logic [7:0]  skip;
        logic [15:0] sid;
        logic [32:0] pts_acc;
        logic [32:0] dts_acc;
        logic [1:0]  tsf;

        function void clear();
            phase = PH_IDLE; bcnt = 0; pkt_len = 0; used = 0; hf = 0; ef = 0;
            hdl = 0; skip = 0; sid = 0; pts_acc = 0; dts_acc = 0; tsf = 0;
        endfunction

        function void emit(logic [1:0] st);
            header_t h;
            h.body_size = 0;
            if (st == ST_OK) begin
                if (used > {1'b0, pkt_len}) st = ST_LONG;
                else h.body_size = 16'(pkt_len - used);
            end
            h.es_id     = sid;
            h.syntax    = (phase <= PH_FIRST) ? SYN_NONE :
                          (phase <= PH_M1_TS) ? SYN_MPEG1 : SYN_MPEG2;
            h.pts_valid = tsf[0];
            h.pts       = tsf[0] ? pts_acc : 33'd0;
            h.dts_valid = tsf[1];
            h.dts       = tsf[1] ? dts_acc : 33'd0;
            h.status    = st;
            expected_headers.push_back(h);
            phase = PH_IDLE;
        endfunction

        function void ts_byte(int k, logic [7:0] c);
            logic [32:0] acc;
            acc = (k < 5) ? pts_acc : dts_acc;
            case (k % 5)
                0: acc = 33'(c[3:1]) << 30;
                1: acc |= 33'(c) << 22;
                2: acc |= 33'(c[7:1]) << 15;
                3: acc |= 33'(c) << 7;
                default: begin
                    acc |= 33'(c[7:1]);
                    if (k < 5) tsf[0] = 1'b1;
                    else tsf[1] = 1'b1;
                end
            endcase
            if (k < 5) pts_acc = acc;
            else dts_acc = acc;
        endfunction

        function int ts_total();
            return hf[6] ? 10 : 5;
        endfunction

        function void walk(walk_t st);
            int n;
            while (1) begin
                case (st)
                    PH_M2_TS: begin
                        if (hf[7]) begin phase = st; bcnt = 0; return; end
                        st = PH_M2_FIX;
                    end
                    PH_M2_FIX: begin
                        n = (hf[5] ? 6 : 0) + (hf[4] ? 3 : 0) + (hf[3] ? 1 : 0) +
                            (hf[2] ? 1 : 0) + (hf[1] ? 2 : 0);
                        if (n != 0) begin phase = st; skip = 8'(n); return; end
                        st = PH_M2_EXTF;
                    end
                    PH_M2_EXTF: begin
                        if (hf[0]) begin phase = st; return; end
                        st = PH_M2_TAIL;
                    end
                    PH_M2_PRIV: begin
                        if (ef[7]) begin phase = st; skip = 8'd16; return; end
                        st = PH_M2_PACKLEN;
                    end
                    PH_M2_PACKLEN: begin
                        if (ef[6]) begin phase = st; return; end
                        st = PH_M2_SEQ;
                    end
                    PH_M2_PACKSKIP: begin
                        if (skip != 0) begin phase = st; return; end
                        st = PH_M2_SEQ;
                    end
                    PH_M2_SEQ: begin
                        n = (ef[5] ? 2 : 0) + (ef[4] ? 2 : 0);
                        if (n != 0) begin phase = st; skip = 8'(n); return; end
                        st = PH_M2_EXTLEN;
                    end
                    PH_M2_EXTLEN: begin
                        if (ef[0]) begin phase = st; return; end
                        st = PH_M2_TAIL;
                    end
                    default: begin
                        if (used >= 17'(3 + hdl)) emit(ST_OK);
                        else phase = PH_M2_TAIL;
                        return;
                    end
                endcase
            end
        endfunction

        function void skip_one(walk_t nxt);
            if (skip != 0) skip--;
            if (skip == 0) walk(nxt);
        endfunction

        function void m1_ts(logic [7:0] c);
            if (c[7:4] == 4'h2 || c[7:4] == 4'h3) begin
                hf = (c[7:4] == 4'h3) ? 8'hc0 : 8'h80;
                ts_byte(0, c);
                bcnt = 1;
                phase = PH_M1_TS;
            end else begin
                emit(ST_OK);
            end
        endfunction

        function void m1_eval(logic [7:0] c);
            if (used < {1'b0, pkt_len} && c[7]) phase = PH_M1_STUFF;
            else if (c[7:6] == 2'b01) phase = PH_M1_STD;
            else m1_ts(c);
        endfunction

        function void note_byte(logic [7:0] c, logic start);
            if (start) begin
                if (phase != PH_IDLE) emit(ST_CUT);
                clear();
                phase = PH_START;
                bcnt = 1;
                return;
            end
            if (phase == PH_IDLE) return;
            if (phase >= PH_FIRST) used = used + 17'd1;
            case (phase)
                PH_START: begin
                    if (bcnt == 3) sid = {8'h00, c};
                    else if (bcnt == 4) pkt_len[15:8] = c;
                    else if (bcnt == 5) pkt_len[7:0] = c;
                    bcnt++;
                    if (bcnt >= 6) begin
                        if (sid[7:0] == ID_PADDING || sid[7:0] == ID_PRIVATE2) emit(ST_OK);
                        else phase = PH_FIRST;
                    end
                end
                PH_FIRST: begin
                    if (c[7:6] == 2'b10) phase = PH_M2_FLAGS;
                    else m1_eval(c);
                end
                PH_M1_STUFF: m1_eval(c);
                PH_M1_STD: phase = PH_M1_AFTER;
                PH_M1_AFTER: m1_ts(c);
                PH_M1_TS: begin
                    ts_byte(bcnt, c);
                    bcnt++;
                    if (bcnt >= ts_total()) emit(ST_OK);
                end
                PH_M2_FLAGS: begin hf = c; phase = PH_M2_HDL; end
                PH_M2_HDL: begin hdl = c; walk(PH_M2_TS); end
                PH_M2_TS: begin
                    ts_byte(bcnt, c);
                    bcnt++;
                    if (bcnt >= ts_total()) walk(PH_M2_FIX);
                end
                PH_M2_FIX: skip_one(PH_M2_EXTF);
                PH_M2_EXTF: begin ef = c; walk(PH_M2_PRIV); end
                PH_M2_PRIV: skip_one(PH_M2_PACKLEN);
                PH_M2_PACKLEN: begin skip = c; walk(PH_M2_PACKSKIP); end
                PH_M2_PACKSKIP: skip_one(PH_M2_SEQ);
                PH_M2_SEQ: skip_one(PH_M2_EXTLEN);
                PH_M2_EXTLEN: begin
                    if (c[6:0] != 0) phase = PH_M2_EXTID;
                    else walk(PH_M2_TAIL);
                end
                PH_M2_EXTID: begin
                    if (!c[7]) sid = {sid[7:0], c};
                    walk(PH_M2_TAIL);
                end
                default: walk(PH_M2_TAIL);
            endcase
        endfunction

        function void check_header(header_t got);
            header_t exp_h;
            if (expected_headers.size() == 0) begin
                $error("unexpected header result, es_id %h", got.es_id);
                errors++;
                return;
            end
            exp_h = expected_headers.pop_front();
            headers_seen++;
            if (got.status == ST_CUT) cut_seen++;
            if (got.status == ST_LONG) long_seen++;
            if (got.es_id !== exp_h.es_id) begin
                $error("es_id exp %h got %h", exp_h.es_id, got.es_id); errors++;
            end
            if (got.syntax !== exp_h.syntax) begin
                $error("syntax exp %0d got %0d", exp_h.syntax, got.syntax); errors++;
            end
            if (got.pts_valid !== exp_h.pts_valid) begin
                $error("pts_valid exp %b got %b", exp_h.pts_valid, got.pts_valid); errors++;
            end
            if (got.pts !== exp_h.pts) begin
                $error("pts exp %h got %h", exp_h.pts, got.pts); errors++;
            end
            if (got.dts_valid !== exp_h.dts_valid) begin
                $error("dts_valid exp %b got %b", exp_h.dts_valid, got.dts_valid); errors++;
            end
            if (got.dts !== exp_h.dts) begin
                $error("dts exp %h got %h", exp_h.dts, got.dts); errors++;
            end
            if (got.body_size !== exp_h.body_size) begin
                $error("body_size exp %0d got %0d", exp_h.body_size, got.body_size);
                errors++;
            end
            if (got.status !== exp_h.status) begin
                $error("status exp %0d got %0d", exp_h.status, got.status); errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_packet_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_es_id;
    logic [1:0]  m_syntax;
    logic        m_pts_valid;
    logic [32:0] m_pts;
    logic        m_dts_valid;
    logic [32:0] m_dts;
    logic [15:0] m_body_size;
    logic [1:0]  m_status;

    pes_scoreboard sb = new();
    logic [8:0]    stream_q[$];
    int            bytes_sent;
    int            s_idle_pct;
    int            r_idle_pct;
    int            idle_cycles;
    int            hold_left;
    bit            hold_req;
    bit            hold_fired;

    pes_header_parser u_top (.*);

    always #1 aclk = ~aclk;

    task automatic send_byte(input logic [7:0] b, input logic st);
        s_valid        <= 1'b1;
        s_data_byte    <= b;
        s_packet_start <= st;
        do @(negedge aclk); while (!s_ready);
        sb.note_byte(b, st);
        bytes_sent++;
        @(posedge aclk);
        if ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < s_idle_pct);
        end
    endtask

    task automatic play_stream();
        while (stream_q.size() != 0) begin
            logic [8:0] w;
            w = stream_q.pop_front();
            send_byte(w[7:0], w[8]);
        end
    endtask

    function automatic void add(logic [7:0] b, logic st = 1'b0);
        stream_q.push_back({st, b});
    endfunction

    function automatic void add_rand(int n);
        repeat (n) add(8'($urandom));
    endfunction

    function automatic void add_start(logic [7:0] id, logic [15:0] len);
        add(8'h00, 1'b1); add(8'h00); add(8'h01); add(id); add(len[15:8]); add(len[7:0]);
    endfunction

    function automatic logic [15:0] rand_len();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 8));
            1: return 16'hffff;
            default: return 16'($urandom_range(9, 700));
        endcase
    endfunction

    function automatic void add_mpeg2(logic [7:0] id);
        logic [7:0] f;
        logic [7:0] e;
        logic [7:0] hl;
        int         n;
        f  = 8'($urandom);
        if ($urandom_range(0, 2) == 0) f[0] = 1'b1;
        e  = 8'($urandom);
        hl = 8'($urandom_range(0, 24));
        add_start(id, rand_len());
        add(8'h80 | 8'($urandom_range(0, 63)));
        add(f);
        add(hl);
        if (f[7]) add_rand(f[6] ? 10 : 5);
        n = (f[5] ? 6 : 0) + (f[4] ? 3 : 0) + (f[3] ? 1 : 0) + (f[2] ? 1 : 0) + (f[1] ? 2 : 0);
        add_rand(n);
        if (f[0]) begin
            add(e);
            if (e[7]) add_rand(16);
            if (e[6]) begin
                n = $urandom_range(0, 5);
                add(8'(n));
                add_rand(n);
            end
            add_rand((e[5] ? 2 : 0) + (e[4] ? 2 : 0));
            if (e[0]) begin
                add($urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'h00);
                add(8'($urandom));
            end
        end
        add_rand(hl + $urandom_range(0, 5));
    endfunction

    function automatic void add_mpeg1(logic [7:0] id);
        add_start(id, rand_len());
        repeat ($urandom_range(0, 3)) add(8'hff);
        if ($urandom_range(0, 1)) begin
            add(8'h40 | 8'($urandom_range(0, 63)));
            add(8'($urandom));
        end
        case ($urandom_range(0, 3))
            0: begin add(8'h20 | 8'($urandom_range(0, 15))); add_rand(4); end
            1: begin add(8'h30 | 8'($urandom_range(0, 15))); add_rand(9); end
            2: add(8'h0f);
            default: add(8'($urandom));
        endcase
        add_rand($urandom_range(0, 4));
    endfunction

    function automatic void add_packet();
        logic [7:0] id;
        int         k;
        int         cut_at;
        id = ($urandom_range(0, 1)) ? 8'($urandom_range(8'hc0, 8'hef)) : 8'($urandom);
        k = $urandom_range(0, 99);
        if (k < 55) add_mpeg2(id);
        else if (k < 80) add_mpeg1(id);
        else if (k < 87) begin
            add_start($urandom_range(0, 1) ? ID_PADDING : ID_PRIVATE2, rand_len());
            add_rand($urandom_range(0, 3));
        end else if (k < 93) add_rand($urandom_range(1, 6));
        else begin
            add(8'($urandom), 1'b1);
            add_rand($urandom_range(0, 12));
        end
        // truncate now and then so that the next start cuts the header short
        if ($urandom_range(0, 9) == 0 && stream_q.size() > 2) begin
            cut_at = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > cut_at) void'(stream_q.pop_back());
        end
    endfunction

    // receiver: random back-pressure plus one long hold-off
    initial begin
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= r_idle_pct);
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_header({m_es_id, m_syntax, m_pts_valid, m_pts, m_dts_valid,
                                 m_dts, m_body_size, m_status});
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        sb.clear();
        sb.errors = 0;
        bytes_sent = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        hold_fired = 1'b0;
        s_idle_pct = 32;
        r_idle_pct = 54;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle bytes, padding, short length, full timestamps, cut
        add(8'hff); add(8'h00);
        add_start(ID_PADDING, 16'hffff);
        add_start(8'he0, 16'd2);
        add(8'h84); add(8'hc0); add(8'd10);
        add(8'h3f); add(8'hff); add(8'hff); add(8'hff); add(8'hff);
        add(8'h1f); add(8'h00); add(8'h01); add(8'h00); add(8'h01);
        add_start(8'hc0, 16'd20);
        add(8'hff); add(8'h45); add(8'h00); add(8'h21); add(8'h00);
        add_start(8'hbd, 16'd0);
        add(8'h00, 1'b1);
        play_stream();

        while (bytes_sent < 850) begin
            if (bytes_sent > 300 && !hold_fired) begin
                hold_req = 1'b1;
                hold_fired = 1'b1;
            end
            if (bytes_sent >= 283 && s_idle_pct == 32) begin
                s_idle_pct = 54;
                r_idle_pct = 32;
                s_valid <= 1'b0;
                @(posedge aclk);
                while (sb.expected_headers.size() != 0) @(posedge aclk);
            end
            if (bytes_sent >= 566) begin
                s_idle_pct = 0;
                r_idle_pct = 0;
            end
            add_packet();
            play_stream();
        end
        s_valid <= 1'b0;
        while (sb.expected_headers.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered %0d stream bytes and %0d headers (%0d cut, %0d over length).",
                 bytes_sent, sb.headers_seen, sb.cut_seen, sb.long_seen);
        if (sb.errors == 0 && sb.expected_headers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
